@@ rtl/core/spli_pkg.sv @@
`timescale 1ns / 1ps
package spli_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;

    // quotient of (t << 16) / time_step: 32 integer bits, 16 fraction bits
    localparam int QW        = 48;
    localparam int DIV_STEPS = QW;
    // divider stages plus address and read, diff, product, value, scale, output
    localparam int LATENCY   = DIV_STEPS + 6;

    localparam logic [2:0] REG_TIME_STEP    = 3'd0;
    localparam logic [2:0] REG_START_TIME   = 3'd1;
    localparam logic [2:0] REG_SCALE_FACTOR = 3'd2;
    localparam logic [2:0] REG_USE_LAST     = 3'd3;
    localparam logic [2:0] REG_PREPEND_ZERO = 3'd4;
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd5;

    // item fields that ride alongside the divider
    typedef struct packed {
        logic        query;
        logic        zero;
        logic [9:0]  idx;
        logic [31:0] value;
    } spli_side_t;

endpackage

@@ rtl/core/spli_ram.sv @@
`timescale 1ns / 1ps
module spli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

@@ rtl/core/spli_divider.sv @@
`timescale 1ns / 1ps
module spli_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  logic [31:0]             in_time,
    input  spli_pkg::spli_side_t    in_side,
    input  logic [31:0]             divisor,
    output logic                    out_vld,
    output logic [spli_pkg::QW-1:0] out_quot,
    output spli_pkg::spli_side_t    out_side
);
    import spli_pkg::*;

    // restoring divider, one quotient bit per stage; w holds the dividend
    // bits not yet used, quotient bits shift in from the bottom
    logic [31:0]   rem_reg  [DIV_STEPS];
    logic [QW-1:0] w_reg    [DIV_STEPS];
    logic          vld_reg  [DIV_STEPS];
    spli_side_t    side_reg [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_stage
            logic [31:0]   rem_in;
            logic [QW-1:0] w_in;
            logic          vld_in;
            spli_side_t    side_in;
            logic [32:0]   trial;
            logic [32:0]   diff;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign w_in    = {in_time, 16'b0};
                assign vld_in  = in_vld;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign w_in    = w_reg[k-1];
                assign vld_in  = vld_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            assign trial = {rem_in, w_in[QW-1]};
            assign ge    = trial >= {1'b0, divisor};
            assign diff  = trial - {1'b0, divisor};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= ge ? diff[31:0] : trial[31:0];
                w_reg[k]    <= {w_in[QW-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    endgenerate

    assign out_vld  = vld_reg[DIV_STEPS-1];
    assign out_quot = w_reg[DIV_STEPS-1];
    assign out_side = side_reg[DIV_STEPS-1];

endmodule

@@ rtl/core/spli_interp.sv @@
`timescale 1ns / 1ps
module spli_interp #(
    parameter int TABLE_DEPTH = spli_pkg::DEF_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int NW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  logic [spli_pkg::QW-1:0] in_quot,
    input  spli_pkg::spli_side_t    in_side,
    input  logic [NW-1:0]           count,
    input  logic                    prepend,
    input  logic                    use_last,
    input  logic signed [23:0]      scale,
    output logic                    done,
    output logic signed [31:0]      factor_value
);
    import spli_pkg::*;

    // ---- stage A: addresses, table write for loads
    logic [31:0] idx_i;
    logic [32:0] i_ext, i_plus, size, n_ext, a0_full, a1_full;
    logic        inrange, first_zero, ram_we;
    logic [AW-1:0] a0, a1, waddr;
    logic [31:0] rd0, rd1;

    assign idx_i      = in_quot[QW-1:16];
    assign i_ext      = {1'b0, idx_i};
    assign i_plus     = i_ext + 33'd1;
    assign n_ext      = 33'(count);
    assign size       = n_ext + 33'(prepend);
    assign inrange    = i_plus < size;
    assign first_zero = prepend && (idx_i == 32'd0);
    assign a0_full    = inrange ? (i_ext - 33'(prepend)) : (n_ext - 33'd1);
    assign a1_full    = i_plus - 33'(prepend);
    assign a0         = a0_full[AW-1:0];
    assign a1         = a1_full[AW-1:0];
    assign waddr      = AW'(in_side.idx);
    assign ram_we     = in_vld && !in_side.query
                        && (32'(in_side.idx) < 32'(TABLE_DEPTH));

    spli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (waddr),
        .wdata  (in_side.value),
        .raddr0 (a0),
        .raddr1 (a1),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    logic        a_vld_reg, a_zero_reg, a_in_reg, a_fz_reg;
    logic [15:0] a_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_vld && in_side.query;
        end
    end

    always_ff @(posedge clk)
    begin
        a_zero_reg <= in_side.zero || (!inrange && !use_last);
        a_in_reg   <= inrange;
        a_fz_reg   <= first_zero;
        a_f_reg    <= in_quot[15:0];
    end

    // ---- stage B: neighbors and their difference
    logic signed [31:0] v1;
    logic signed [32:0] diff;
    logic               b_vld_reg, b_zero_reg, b_in_reg;
    logic signed [31:0] b_v1_reg;
    logic signed [32:0] b_diff_reg;
    logic [15:0]        b_f_reg;

    assign v1   = a_fz_reg ? 32'sd0 : $signed(rd0);
    assign diff = {rd1[31], rd1} - {v1[31], v1};

    // ---- stage C: slope times fraction
    logic signed [16:0] f_s;
    logic signed [49:0] prod;
    logic               c_vld_reg, c_zero_reg, c_in_reg;
    logic signed [31:0] c_v1_reg;
    logic signed [49:0] c_prod_reg;

    assign f_s  = $signed({1'b0, b_f_reg});
    assign prod = b_diff_reg * f_s;

    // ---- stage D: interpolated value, the sum floored to Q16.16
    logic signed [50:0] sum;
    logic               d_vld_reg, d_zero_reg;
    logic signed [31:0] d_val_reg;

    assign sum = {{3{c_v1_reg[31]}}, c_v1_reg, 16'b0} + {c_prod_reg[49], c_prod_reg};

    // ---- stage E: scale
    logic signed [55:0] m;
    logic               e_vld_reg, e_zero_reg;
    logic signed [55:0] e_m_reg;

    assign m = d_val_reg * scale;

    // ---- stage F: floor shift and saturation
    logic [39:0]        sh;
    logic               ovf;
    logic signed [31:0] sat;

    assign sh  = e_m_reg[55:16];
    assign ovf = !((sh[39:31] == 9'h000) || (sh[39:31] == 9'h1ff));
    assign sat = !ovf ? $signed(sh[31:0])
               : (sh[39] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            done      <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_zero_reg   <= a_zero_reg;
        b_in_reg     <= a_in_reg;
        b_v1_reg     <= v1;
        b_diff_reg   <= diff;
        b_f_reg      <= a_f_reg;

        c_zero_reg   <= b_zero_reg;
        c_in_reg     <= b_in_reg;
        c_v1_reg     <= b_v1_reg;
        c_prod_reg   <= prod;

        d_zero_reg   <= c_zero_reg;
        d_val_reg    <= c_in_reg ? sum[47:16] : c_v1_reg;

        e_zero_reg   <= d_zero_reg;
        e_m_reg      <= m;

        factor_value <= e_zero_reg ? 32'sd0 : sat;
    end

endmodule

@@ rtl/core/sampled_path_linear_interpolator.sv @@
`timescale 1ns / 1ps
// Piecewise linear interpolator over a table of equally spaced Q16.16
// samples. One item is taken per cycle whenever start is high (busy stays
// low): a load (kind 0) writes sample_value at sample_index, a query
// (kind 1) returns one factor_value with a one-cycle done strobe; loads
// give no result. A query passes through the 48-stage pipelined divider
// forming (query_time << 16) / time_step, followed by the table read and
// five arithmetic stages (difference, slope product, interpolated value,
// scale, saturation). Loads travel the same pipe, so a query always sees
// every load taken before it. The receiver cannot stall; results must be
// taken when done is high. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while no item is in flight; the block
// itself does not enforce this. A table entry read before it was ever
// loaded gives an unspecified result.
module sampled_path_linear_interpolator #(
    parameter int TABLE_DEPTH = spli_pkg::DEF_TABLE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [9:0]         sample_index,
    input  logic signed [31:0] sample_value,
    input  logic [31:0]        query_time,
    output logic               done,
    output logic signed [31:0] factor_value,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import spli_pkg::*;

    localparam int NW = $clog2(TABLE_DEPTH + 1);

    // configuration registers
    logic [31:0]        time_step_reg;
    logic [31:0]        start_time_reg;
    logic signed [23:0] scale_factor_reg;
    logic               use_last_reg;
    logic               prepend_zero_reg;
    logic [10:0]        sample_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg    <= 32'h0001_0000;
            start_time_reg   <= 32'd0;
            scale_factor_reg <= 24'sh01_0000;
            use_last_reg     <= 1'b0;
            prepend_zero_reg <= 1'b0;
            sample_count_reg <= 11'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_STEP:    time_step_reg    <= cfg_data;
                REG_START_TIME:   start_time_reg   <= cfg_data;
                REG_SCALE_FACTOR: scale_factor_reg <= $signed(cfg_data[23:0]);
                REG_USE_LAST:     use_last_reg     <= cfg_data[0];
                REG_PREPEND_ZERO: prepend_zero_reg <= cfg_data[0];
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[10:0];
                default:          ;
            endcase
        end
    end

    // loaded entries in use, clamped to the table depth
    logic [31:0]   count_wide;
    logic [NW-1:0] count_used;

    assign count_wide = 32'(sample_count_reg);
    assign count_used = (count_wide > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                       : NW'(count_wide);

    // the pipe never stalls
    assign busy = 1'b0;

    logic       accept;
    spli_side_t side;

    assign accept     = start && !busy;
    assign side.query = kind;
    // empty table, time before start, or zero step: result is zero
    assign side.zero  = (count_used == '0) || (query_time < start_time_reg)
                        || (time_step_reg == 32'd0);
    assign side.idx   = sample_index;
    assign side.value = sample_value;

    logic          div_vld;
    logic [QW-1:0] div_quot;
    spli_side_t    div_side;

    spli_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (accept),
        .in_time  (query_time),
        .in_side  (side),
        .divisor  (time_step_reg),
        .out_vld  (div_vld),
        .out_quot (div_quot),
        .out_side (div_side)
    );

    spli_interp #(.TABLE_DEPTH(TABLE_DEPTH)) u_interp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (div_vld),
        .in_quot      (div_quot),
        .in_side      (div_side),
        .count        (count_used),
        .prepend      (prepend_zero_reg),
        .use_last     (use_last_reg),
        .scale        (scale_factor_reg),
        .done         (done),
        .factor_value (factor_value)
    );

endmodule

@@ rtl/core/spli_checker.sv @@
`timescale 1ns / 1ps
module spli_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic kind
,   input logic done
);
    import spli_pkg::*;

    // every query answers after the fixed latency
    a_query_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && kind |-> ##LATENCY done)
        else $error("query gave no result");

    // loads never answer
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !kind |-> ##LATENCY !done)
        else $error("load gave a result");

    // no result without a query before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && kind, LATENCY))
        else $error("result without a query");

endmodule

bind sampled_path_linear_interpolator spli_checker u_chk (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import spli_pkg::*;

    // item kinds on the kind port
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
    localparam int   DEPTH      = DEF_TABLE_DEPTH;
    // settle time after the last item before config may change (loads ride the pipe too)
    localparam int   SETTLE     = LATENCY + 4;
    localparam int   CYCLE_LIMIT = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               kind = KIND_LOAD;
    logic [9:0]         sample_index = '0;
    logic signed [31:0] sample_value = '0;
    logic [31:0]        query_time = '0;
    logic               done;
    logic signed [31:0] factor_value;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = REG_TIME_STEP;
    logic [31:0]        cfg_data = '0;

    sampled_path_linear_interpolator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .query_time   (query_time),
        .done         (done),
        .factor_value (factor_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // shadow copy of the block's registers and sample table
    logic [31:0]        step_q;
    logic [31:0]        start_q;
    logic signed [23:0] scale_q;
    logic               hold_last_q;
    logic               lead_zero_q;
    logic [10:0]        count_q;
    logic signed [31:0] samples [DEPTH];

    logic signed [31:0] factor_queue [$];
    int                 fail_cnt = 0;
    int                 cycle_cnt = 0;
    int                 idle_pct = 34;

    function automatic logic signed [31:0] clip32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // virtual table entry: optional zero in front of the loaded samples
    function automatic longint entry_at(longint k);
        if (lead_zero_q && k == 0)
            return 0;
        return longint'(samples[k - lead_zero_q]);
    endfunction

    function automatic logic signed [31:0] interp_factor(logic [31:0] t);
        longint n, sz, tt, st, i, r, f, v1, v2, val, sf;
        n  = (count_q > DEPTH) ? DEPTH : count_q;
        tt = t;
        st = step_q;
        sf = scale_q;
        if (n == 0 || t < start_q || st == 0)
            return '0;
        sz = n + lead_zero_q;
        i  = tt / st;
        r  = tt % st;
        if (i + 1 < sz)
        begin
            f   = (r << 16) / st;
            v1  = entry_at(i);
            v2  = entry_at(i + 1);
            val = (v1 * 65536 + (v2 - v1) * f) >>> 16;
            return clip32((val * sf) >>> 16);
        end
        if (hold_last_q)
            return clip32((longint'(samples[n - 1]) * sf) >>> 16);
        return '0;
    endfunction

    // results are taken at the edge that ends their strobe cycle
    always @(posedge clk)
    begin
        if (done)
        begin
            if (factor_queue.size() == 0)
            begin
                $error("factor_value: unexpected result %0d", factor_value);
                fail_cnt++;
            end
            else
            begin
                if (factor_value !== factor_queue[0])
                begin
                    $error("factor_value: expected %0d actual %0d",
                           factor_queue[0], factor_value);
                    fail_cnt++;
                end
                void'(factor_queue.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("sampled_path_linear_interpolator verification failed");
            $finish;
        end
    end

    // one item; random idle cycles first, then hold start until taken
    task automatic send_item(logic k, logic [9:0] idx, logic [31:0] val, logic [31:0] t);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= k;
        sample_index <= idx;
        sample_value <= val;
        query_time   <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (k == KIND_LOAD)
            samples[idx] = val;
        else
            factor_queue.push_back(interp_factor(t));
    endtask

    task automatic load(logic [9:0] idx, logic [31:0] val);
        send_item(KIND_LOAD, idx, val, $urandom());
    endtask

    task automatic query(logic [31:0] t);
        send_item(KIND_QUERY, 10'($urandom()), $urandom(), t);
    endtask

    // block must be empty before config writes
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (factor_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_TIME_STEP:    step_q      = data;
            REG_START_TIME:   start_q     = data;
            REG_SCALE_FACTOR: scale_q     = data[23:0];
            REG_USE_LAST:     hold_last_q = data[0];
            REG_PREPEND_ZERO: lead_zero_q = data[0];
            REG_SAMPLE_COUNT: count_q     = data[10:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup(logic [31:0] stp, logic [31:0] st0, logic [23:0] sf,
                         logic hl, logic lz, logic [10:0] cnt);
        drain();
        write_reg(REG_TIME_STEP, stp);
        write_reg(REG_START_TIME, st0);
        write_reg(REG_SCALE_FACTOR, {{8{sf[23]}}, sf});
        write_reg(REG_USE_LAST, 32'(hl));
        write_reg(REG_PREPEND_ZERO, 32'(lz));
        write_reg(REG_SAMPLE_COUNT, 32'(cnt));
    endtask

    // a time that lands on a chosen table interval, or sometimes anywhere
    function automatic logic [31:0] pick_time();
        longint sz, t;
        sz = ((count_q > DEPTH) ? DEPTH : count_q) + lead_zero_q;
        if ($urandom_range(9, 0) == 0)
            return $urandom();
        t = longint'($urandom_range(sz, 0)) * step_q + ($urandom() % step_q);
        if (t > 64'hFFFFFFFF)
            return $urandom();
        return t[31:0];
    endfunction

    // empty table right after reset: every query is zero
    task automatic test_empty_table();
        query(32'd0);
        query(32'hFFFFFFFF);
        query(32'h00018000);
    endtask

    // write every entry so no query can touch an unwritten one
    task automatic test_fill_table();
        load(10'd0, 32'h7FFFFFFF);
        load(10'd1, 32'h80000000);
        for (int k = 2; k < DEPTH; k++)
            load(10'(k), $urandom());
    endtask

    task automatic test_directed();
        // identity scale, four samples, plain interpolation and past the end
        setup(32'd65536, 32'd0, 24'd65536, 1'b0, 1'b0, 11'd4);
        load(10'd2, 32'h00020000);
        load(10'd3, 32'hFFFF0000);
        load(10'd1023, 32'h12345678);
        query(32'd0);
        query(32'h00018000);
        query(32'h00028000);
        query(32'h00030000);
        query(32'hFFFFFFFF);
        // hold the last sample, leading zero entry, time below start
        setup(32'd65536, 32'h00010000, 24'd65536, 1'b1, 1'b1, 11'd4);
        query(32'h0000FFFF);
        query(32'h00010000);
        query(32'h00008000);
        query(32'h00040000);
        query(32'hFFFFFFFF);
        // scale extremes drive saturation both ways
        setup(32'd1, 32'd0, 24'h7FFFFF, 1'b1, 1'b0, 11'd2);
        query(32'd0);
        query(32'd1);
        query(32'd5);
        setup(32'hFFFFFFFF, 32'd0, 24'h800000, 1'b1, 1'b0, 11'd1024);
        query(32'd0);
        query(32'h80000000);
        query(32'hFFFFFFFE);
        query(32'hFFFFFFFF);
    endtask

    task automatic test_random_phases();
        logic [31:0] stp, st0;
        logic [23:0] sf;
        logic [10:0] cnt;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph % 5)
                0: stp = 32'd1;
                1: stp = 32'd65536;
                2: stp = 32'hFFFFFFFF;
                3: stp = $urandom_range(1 << 20, 1);
                default: stp = $urandom() | 32'd1;
            endcase
            case ($urandom_range(4, 0))
                0: cnt = 11'd0;
                1: cnt = 11'd1;
                2: cnt = 11'd1024;
                default: cnt = 11'($urandom_range(1024, 2));
            endcase
            case ($urandom_range(3, 0))
                0: sf = 24'h800000;
                1: sf = 24'h7FFFFF;
                default: sf = 24'($urandom());
            endcase
            st0 = ($urandom_range(2, 0) == 0) ? $urandom() : $urandom_range(3 * stp, 0);
            setup(stp, st0, sf, 1'($urandom()), 1'($urandom()), cnt);
            // one phase runs with no idling at all
            idle_pct = (ph == 3) ? 0 : 34;
            for (int n = 0; n < 50; n++)
            begin
                if ($urandom_range(99, 0) < 15)
                    load(10'($urandom()), $urandom());
                else
                    query(pick_time());
            end
            idle_pct = 34;
        end
    endtask

    initial
    begin
        step_q      = 32'd65536;
        start_q     = 32'd0;
        scale_q     = 24'd65536;
        hold_last_q = 1'b0;
        lead_zero_q = 1'b0;
        count_q     = 11'd0;
        for (int k = 0; k < DEPTH; k++)
            samples[k] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_fill_table();
        test_directed();
        test_random_phases();
        drain();

        if (fail_cnt == 0)
            $display("sampled_path_linear_interpolator verification clean");
        else
            $display("sampled_path_linear_interpolator verification failed");
        $finish;
    end

endmodule

@@ sampled_path_linear_interpolator.f @@
rtl/core/spli_pkg.sv
rtl/core/spli_ram.sv
rtl/core/spli_divider.sv
rtl/core/spli_interp.sv
rtl/core/sampled_path_linear_interpolator.sv
rtl/core/spli_checker.sv
test/tb.sv
